[sv/moisture_pump_controller_assert.svh]
// Assertion macros for the moisture pump controller checker.
// Each macro expects clk and rst_n in scope where it is used.
`ifndef MOISTURE_PUMP_CONTROLLER_ASSERT_SVH
`define MOISTURE_PUMP_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define MPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mpc_pkg.sv]
// Shared types and constants for the moisture pump controller.
// No dependencies; used by the top level and its checker.
`default_nettype none

package mpc_pkg;

    // Fixed field widths
    localparam int LEVEL_BITS   = 10;
    localparam int TIMEOUT_BITS = 24;
    localparam int RETRY_BITS   = 4;
    localparam int MODE_BITS    = 2;
    localparam int CMD_BITS     = 2;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    // Default parameter values
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int TIME_BITS_DEF   = 32;

    // Register reset values
    localparam logic [LEVEL_BITS-1:0]   TARGET_RESET  = 10'd600;
    localparam logic [LEVEL_BITS-1:0]   DRY_RESET     = 10'd950;
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 24'd5000;
    localparam logic [RETRY_BITS-1:0]   LIMIT_RESET   = 4'd3;
    localparam logic [RETRY_BITS-1:0]   RETRY_MAX     = 4'd15;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_TARGET  = 2'd0;
    localparam logic [1:0] REG_DRY     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_LIMIT   = 2'd3;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_FORCE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_STOP  = 2'd2;

    // Mode codes as seen on the result word
    localparam logic [MODE_BITS-1:0] MODE_IDLE      = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_FEEDING   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_FINISHING = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_FORCED    = 2'd3;

    // Controller state, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FEED   = 4'b0010,
        ST_FINISH = 4'b0100,
        ST_FORCED = 4'b1000
    } state_t;

    // Map a state to its mode code
    function automatic logic [MODE_BITS-1:0] state_to_mode(input state_t st);
        logic [MODE_BITS-1:0] m;
        begin
            unique case (st)
                ST_IDLE:   m = MODE_IDLE;
                ST_FEED:   m = MODE_FEEDING;
                ST_FINISH: m = MODE_FINISHING;
                ST_FORCED: m = MODE_FORCED;
                default:   m = MODE_IDLE;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

[sv/moisture_pump_controller.sv]
// Moisture pump controller: one polling pass per input word, APB register file.
// Depends on mpc_pkg.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------
//  in       | to block  | in_valid/in_ready  | sample, now_ms, cmd
//  out      | from block| out_valid/out_ready| pump_on, mode, retries_used,
//           |           |                    | timeout_seen, cmd_refused
//  apb      | to block  | psel/penable       | paddr, pwdata, prdata
//
// One word per cycle: a pass is computed from the input ports and the state
// registers in the accept cycle and lands in the output register in the next cycle.
// The output register frees when taken, so a new word is accepted in the same
// cycle that the previous result leaves; a stalled output blocks input.
// Reset clears state, registers to defaults and the output valid flag.
`default_nettype none

module moisture_pump_controller #(
    parameter int SAMPLE_BITS = mpc_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = mpc_pkg::TIME_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [SAMPLE_BITS-1:0]            sample,
    input  wire logic [TIME_BITS-1:0]              now_ms,
    input  wire logic [mpc_pkg::CMD_BITS-1:0]      cmd,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   pump_on,
    output logic [mpc_pkg::MODE_BITS-1:0]          mode,
    output logic [mpc_pkg::RETRY_BITS-1:0]         retries_used,
    output logic                                   timeout_seen,
    output logic                                   cmd_refused,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mpc_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [mpc_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [mpc_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                   pready
);

    import mpc_pkg::*;

    localparam int CMP_W  = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
    localparam int TCMP_W = (TIME_BITS > TIMEOUT_BITS) ? TIME_BITS : TIMEOUT_BITS;

    // Configuration registers
    logic [LEVEL_BITS-1:0]   target_reg;
    logic [LEVEL_BITS-1:0]   dry_reg;
    logic [TIMEOUT_BITS-1:0] timeout_reg;
    logic [RETRY_BITS-1:0]   limit_reg;

    // Controller state
    state_t                  state_reg, state_next, state_eff;
    logic [TIME_BITS-1:0]    start_reg, start_next, start_eff;
    logic [RETRY_BITS-1:0]   retry_reg, retry_next;
    logic                    error_reg, error_next;
    logic                    pump_reg, pump_next, pump_eff;

    // Output register
    logic                    out_valid_reg;
    logic                    pump_on_reg;
    logic [MODE_BITS-1:0]    mode_reg;
    logic [RETRY_BITS-1:0]   retries_reg;
    logic                    timeout_seen_reg, timeout_seen_next;
    logic                    refused_reg, refused_next;

    logic                    in_fire;
    logic                    apb_write;
    logic [CMP_W-1:0]        sample_x, target_x, dry_x;
    logic [TIME_BITS-1:0]    elapsed;
    logic                    expired;

    // Handshake: accept whenever the output register is free or draining
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign apb_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= TARGET_RESET;
            dry_reg     <= DRY_RESET;
            timeout_reg <= TIMEOUT_RESET;
            limit_reg   <= LIMIT_RESET;
        end
        else if (apb_write)
        begin
            unique case (paddr[3:2])
                REG_TARGET:  target_reg  <= pwdata[LEVEL_BITS-1:0];
                REG_DRY:     dry_reg     <= pwdata[LEVEL_BITS-1:0];
                REG_TIMEOUT: timeout_reg <= pwdata[TIMEOUT_BITS-1:0];
                REG_LIMIT:   limit_reg   <= pwdata[RETRY_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[3:2])
            REG_TARGET:  prdata = APB_DATA_BITS'(target_reg);
            REG_DRY:     prdata = APB_DATA_BITS'(dry_reg);
            REG_TIMEOUT: prdata = APB_DATA_BITS'(timeout_reg);
            REG_LIMIT:   prdata = APB_DATA_BITS'(limit_reg);
            default:     prdata = '0;
        endcase
    end

    // Apply the command ahead of the state machine
    always_comb
    begin
        state_eff    = state_reg;
        start_eff    = start_reg;
        pump_eff     = pump_reg;
        refused_next = 1'b0;
        if (cmd == CMD_FORCE)
        begin
            if (state_reg == ST_IDLE)
            begin
                state_eff = ST_FORCED;
                start_eff = now_ms;
                pump_eff  = 1'b1;
            end
            else
            begin
                refused_next = 1'b1;
            end
        end
        else if (cmd == CMD_STOP)
        begin
            state_eff = ST_FINISH;
        end
    end

    // Wrap-safe run time and level compares
    assign elapsed  = now_ms - start_eff;
    assign expired  = TCMP_W'(elapsed) > TCMP_W'(timeout_reg);
    assign sample_x = CMP_W'(sample);
    assign target_x = CMP_W'(target_reg);
    assign dry_x    = CMP_W'(dry_reg);

    // One pass of the state machine
    always_comb
    begin
        state_next        = state_eff;
        start_next        = start_eff;
        pump_next         = pump_eff;
        retry_next        = retry_reg;
        error_next        = error_reg;
        timeout_seen_next = 1'b0;
        unique case (state_eff)
            ST_IDLE:
            begin
                if (sample_x > dry_x && retry_reg < limit_reg)
                begin
                    pump_next  = 1'b1;
                    state_next = ST_FEED;
                    start_next = now_ms;
                end
                if (sample_x < target_x && retry_reg >= limit_reg)
                begin
                    retry_next = '0;
                    error_next = 1'b0;
                end
            end
            ST_FEED:
            begin
                if (sample_x < target_x || expired)
                begin
                    pump_next  = 1'b0;
                    state_next = ST_FINISH;
                end
                if (expired)
                begin
                    error_next = 1'b1;
                end
            end
            ST_FORCED:
            begin
                if (expired)
                begin
                    pump_next  = 1'b0;
                    state_next = ST_FINISH;
                    error_next = 1'b0;
                    retry_next = '0;
                end
            end
            ST_FINISH:
            begin
                // count a timeout retry, saturating; a clean run clears the count
                if (error_reg)
                begin
                    if (retry_reg != RETRY_MAX)
                    begin
                        retry_next = retry_reg + 4'd1;
                    end
                    timeout_seen_next = 1'b1;
                    error_next        = 1'b0;
                end
                else
                begin
                    retry_next = '0;
                end
                pump_next  = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                pump_next  = 1'b0;
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= '0;
            retry_reg <= '0;
            error_reg <= 1'b0;
            pump_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            retry_reg <= retry_next;
            error_reg <= error_next;
            pump_reg  <= pump_next;
        end
    end

    // Output valid: set on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: hold until the next accepted word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pump_on_reg      <= pump_next;
            mode_reg         <= state_to_mode(state_next);
            retries_reg      <= retry_next;
            timeout_seen_reg <= timeout_seen_next;
            refused_reg      <= refused_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pump_on      = pump_on_reg;
    assign mode         = mode_reg;
    assign retries_used = retries_reg;
    assign timeout_seen = timeout_seen_reg;
    assign cmd_refused  = refused_reg;

endmodule

`default_nettype wire

[sv/mpc_checker.sv]
// Port-level checker for the moisture pump controller, bound to the top level.
// Depends on mpc_pkg and moisture_pump_controller_assert.svh.
`default_nettype none

`include "moisture_pump_controller_assert.svh"

module mpc_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic                         pump_on,
    input wire logic [mpc_pkg::MODE_BITS-1:0]  mode,
    input wire logic [mpc_pkg::RETRY_BITS-1:0] retries_used,
    input wire logic                         timeout_seen,
    input wire logic                         cmd_refused
);

    import mpc_pkg::*;

    // A stalled result word holds
    `MPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mode) && $stable(pump_on) && $stable(retries_used), "result word changed while stalled")

    // Pump runs exactly in the two feeding modes
    `MPC_ASSERT_NOW(a_pump_mode, out_valid, pump_on == (mode == MODE_FEEDING || mode == MODE_FORCED), "pump state disagrees with mode")

    // A refused force feed that lands in idle has just closed a finishing pass
    `MPC_ASSERT_NOW(a_refused_busy, out_valid && cmd_refused && mode == MODE_IDLE, timeout_seen || retries_used == 4'd0, "refused force feed in idle without a finishing pass")

    // A counted timeout returns to idle with a nonzero count
    `MPC_ASSERT_NOW(a_timeout_idle, out_valid && timeout_seen, mode == MODE_IDLE && retries_used != 4'd0, "timeout retry reported outside idle or with zero count")

endmodule

bind moisture_pump_controller mpc_checker u_mpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pump_on      (pump_on),
    .mode         (mode),
    .retries_used (retries_used),
    .timeout_seen (timeout_seen),
    .cmd_refused  (cmd_refused)
);

`default_nettype wire
